### src/ptc_pkg.sv
// Package for the pressure and temperature compensation block: word types, codes and helpers.
package ptc_pkg;

    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_COEF   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_MID   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_HIGH  = 2'd3;

    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] HALF_SCALE   = 32'd32768;
    localparam logic [31:0] ADC_FULL     = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] ROUND_CENTI  = 32'd128;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] fine_temperature;
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
    } t_out_word;

    // Working set carried by every pipeline stage.
    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [19:0] adc_p;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        post_shift;
        logic        zero_div;
    } t_stage;

    // Arithmetic right shift of a 32-bit two's complement pattern.
    function automatic logic [31:0] f_sra(input logic [31:0] v, input int unsigned n);
        f_sra = 32'($signed(v) >>> n);
    endfunction

    // 16-bit field sign extended to 32 bits.
    function automatic logic [31:0] f_s16(input logic [15:0] v);
        f_s16 = {{16{v[15]}}, v};
    endfunction

endpackage

### src/pressure_temperature_compensation.sv
// Top level of the pipelined 32-bit integer pressure and temperature compensation.
//
//  Channel | Direction | Handshake                   | Word
//  --------+-----------+-----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready     | raw temperature, raw pressure
//  out     | output    | o_out_valid / i_out_ready   | fine temp, centi temp, pressure
//  cfg     | input     | i_cfg_we (no wait)          | index and 48-bit coefficient set
//
// The block is a 49-stage pipeline and accepts one word in every cycle while the output
// is not stalled; the input word is registered in the first stage on the accepting edge.
// 32 of the stages are the unsigned divider for pressure, one quotient bit a stage.
// All stages move together; when the output word is held and not taken, the whole
// pipeline freezes and o_in_ready falls, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits and the coefficients.
module pressure_temperature_compensation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ptc_pkg::t_in_word                    i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ptc_pkg::t_out_word                   o_out,
    input  logic                                 i_cfg_we,
    input  logic [ptc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ptc_pkg::*;

    localparam int unsigned NST      = 49;
    localparam int unsigned DIV_FIRST = 13;
    localparam int unsigned DIV_LAST  = 44;
    localparam int unsigned LAST      = NST - 1;

    logic [CFG_DATA_W-1:0] r_tc, r_pl, r_pm, r_ph;
    t_stage                r_s [NST];
    t_stage                n_s [NST];
    logic [NST-1:0]        r_v;
    logic                  w_adv;

    // Coefficients, unpacked and extended.
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = f_s16(r_tc[31:16]);
    assign t3 = f_s16(r_tc[47:32]);
    assign p1 = {16'd0, r_pl[15:0]};
    assign p2 = f_s16(r_pl[31:16]);
    assign p3 = f_s16(r_pl[47:32]);
    assign p4 = f_s16(r_pm[15:0]);
    assign p5 = f_s16(r_pm[31:16]);
    assign p6 = f_s16(r_pm[47:32]);
    assign p7 = f_s16(r_ph[15:0]);
    assign p8 = f_s16(r_ph[31:16]);
    assign p9 = f_s16(r_ph[47:32]);

    // The pipeline moves whenever the output stage is empty or being taken.
    assign w_adv      = !r_v[LAST] || i_out_ready;
    assign o_in_ready = w_adv;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pl <= '0;
            r_pm <= '0;
            r_ph <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_COEF:  r_tc <= i_cfg_data;
                CFG_PRESS_LOW:  r_pl <= i_cfg_data;
                CFG_PRESS_MID:  r_pm <= i_cfg_data;
                CFG_PRESS_HIGH: r_ph <= i_cfg_data;
                default:        r_tc <= r_tc;
            endcase
        end
    end

    // Stage logic. Each stage after the first reads only its predecessor's register.
    always_comb begin
        logic [31:0] adc_t;
        logic [31:0] q;
        logic [32:0] trial;
        logic [31:0] pq;

        adc_t = {12'd0, i_in.raw_temperature};
        q     = '0;
        trial = '0;
        pq    = '0;
        for (int k = 0; k < NST; k++) begin
            n_s[k] = (k == 0) ? r_s[0] : r_s[k-1];
        end

        // Stage 0: temperature differences.
        n_s[0]       = r_s[0];
        n_s[0].adc_p = i_in.raw_pressure;
        n_s[0].x     = (adc_t >> 3) - (t1 << 1);
        n_s[0].y     = (adc_t >> 4) - t1;
        // Stage 1: first products of the temperature path.
        n_s[1].x = r_s[0].x * t2;
        n_s[1].y = r_s[0].y * r_s[0].y;
        // Stage 2.
        n_s[2].x = f_sra(r_s[1].x, 11);
        n_s[2].y = f_sra(r_s[1].y, 12) * t3;
        // Stage 3: fine temperature.
        n_s[3].fine = r_s[2].x + f_sra(r_s[2].y, 14);
        // Stage 4: rounding term and pressure offset.
        n_s[4].centi = r_s[3].fine + (r_s[3].fine << 2) + ROUND_CENTI;
        n_s[4].x     = f_sra(r_s[3].fine, 1) - FINE_OFFSET;
        // Stage 5: the square and the two linear products.
        q            = f_sra(r_s[4].x, 2);
        n_s[5].centi = f_sra(r_s[4].centi, 8);
        n_s[5].y     = q * q;
        n_s[5].z     = r_s[4].x * p5;
        n_s[5].w     = p2 * r_s[4].x;
        // Stage 6.
        n_s[6].x = f_sra(r_s[5].y, 11) * p6;
        n_s[6].y = p3 * f_sra(r_s[5].y, 13);
        // Stage 7.
        n_s[7].x = r_s[6].x + (r_s[6].z << 1);
        n_s[7].y = f_sra(f_sra(r_s[6].y, 3) + f_sra(r_s[6].w, 1), 18);
        // Stage 8.
        n_s[8].x = f_sra(r_s[7].x, 2) + (p4 << 16);
        n_s[8].y = HALF_SCALE + r_s[7].y;
        // Stage 9: divisor product.
        n_s[9].y = r_s[8].y * p1;
        // Stage 10: divisor and raw numerator.
        n_s[10].y = f_sra(r_s[9].y, 15);
        n_s[10].x = (ADC_FULL - {12'd0, r_s[9].adc_p}) - f_sra(r_s[9].x, 12);
        // Stage 11.
        n_s[11].x = r_s[10].x * PRESS_SCALE;
        // Stage 12: pick the numerator form that does not overflow.
        n_s[12].post_shift = r_s[11].x[31];
        n_s[12].x          = r_s[11].x[31] ? r_s[11].x : (r_s[11].x << 1);
        n_s[12].z          = '0;
        n_s[12].w          = '0;
        n_s[12].zero_div   = (r_s[11].y == '0);
        // Restoring divider, one quotient bit a stage.
        for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
            trial    = {r_s[k-1].z, r_s[k-1].x[31]};
            n_s[k].x = r_s[k-1].x << 1;
            if (trial >= {1'b0, r_s[k-1].y}) begin
                n_s[k].z = 32'(trial - {1'b0, r_s[k-1].y});
                n_s[k].w = {r_s[k-1].w[30:0], 1'b1};
            end else begin
                n_s[k].z = trial[31:0];
                n_s[k].w = {r_s[k-1].w[30:0], 1'b0};
            end
        end
        // Stage 45: undo the numerator choice.
        n_s[45].x = r_s[44].post_shift ? (r_s[44].w << 1) : r_s[44].w;
        // Stage 46: correction products.
        pq        = r_s[45].x >> 3;
        n_s[46].y = pq * pq;
        n_s[46].z = (r_s[45].x >> 2) * p8;
        // Stage 47.
        n_s[47].y = p9 * (r_s[46].y >> 13);
        n_s[47].z = f_sra(r_s[46].z, 13);
        // Stage 48: final pressure, forced to zero for a zero divisor.
        n_s[48].x = r_s[47].zero_div ? '0 :
                    r_s[47].x + f_sra(f_sra(r_s[47].y, 12) + r_s[47].z + p7, 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NST-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NST; k++) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_out_valid             = r_v[LAST];
    assign o_out.fine_temperature  = r_s[LAST].fine;
    assign o_out.temperature_centi = r_s[LAST].centi;
    assign o_out.pressure_pa       = r_s[LAST].x;

    // The input is only held off by a word waiting at the output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    // An accepted word enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("accepted word did not enter the pipeline");

    // A zero divisor always yields zero pressure.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_s[LAST].zero_div) |-> (o_out.pressure_pa == '0))
        else $error("zero divisor gave non-zero pressure");

    // A frozen pipeline keeps its valid pattern.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_v == $past(r_v)))
        else $error("valid bits moved during a stall");

endmodule
